>>> hw/rtl/gbd_pkg.sv
// ----------------------------------------------------------------------------
// gbd_pkg
// Shared types and constants of the 2x2 grayscale box downscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package gbd_pkg;

   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int HEIGHT_LIMIT      = 1024;

   localparam int CFG_W     = 11;
   localparam int PIX_W     = 8;
   localparam int PAIR_W    = 9;
   localparam int ROW_W     = 10;
   localparam int CSR_IDX_W = 2;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd320;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd240;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   // one line store access caused by an accepted pixel
   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic              row_end;
      logic              frame_end;
      logic [PAIR_W-1:0] pair;
   } line_op_type;

endpackage

`default_nettype wire

>>> hw/rtl/gray_box_downscale_2x2_core.sv
// ----------------------------------------------------------------------------
// gray_box_downscale_2x2_core
// 2x2 box filter downscaler for 8-bit grayscale pixels in raster order.
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_stall  | pixel_value, frame_start
//   rsp_    | out       | rsp_valid/rsp_stall  | scaled_pixel, row_end, frame_end
//   csr_    | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// One pixel per clock sustained while the output is not stalled. After its last
// pixel, a result passes the line store read register and then the output register.
// Odd-row pairs read the line store, even-row pairs write it; no clearing pass.
// Reset restores counters and size registers; the line store keeps its data.
// A stalled result holds; one more result may wait in the read stage behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module gray_box_downscale_2x2_core #(
   parameter int MAX_WIDTH = gbd_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [gbd_pkg::PIX_W-1:0]       req_pixel_value,
   input  wire logic                            req_frame_start,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [gbd_pkg::PIX_W-1:0]       rsp_scaled_pixel,
   output logic                                 rsp_row_end,
   output logic                                 rsp_frame_end,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [gbd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [gbd_pkg::CFG_W-1:0]       csr_data
);

   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int IDXW       = $clog2(LINE_DEPTH);

   logic [gbd_pkg::CFG_W-1:0]  width_ff, width_in, height_ff, height_in;
   logic                       accept, out_free, s1_free;
   logic [IDXW-1:0]            line_idx;
   gbd_pkg::line_op_type       line_op;
   logic [gbd_pkg::PAIR_W-1:0] rd_data;

   logic                       s1_valid_ff, s1_valid_in;
   logic [gbd_pkg::PAIR_W-1:0] s1_pair_ff;
   logic                       s1_rend_ff, s1_fend_ff;
   logic                       out_valid_ff, out_valid_in;
   logic [gbd_pkg::PIX_W-1:0]  out_pix_ff;
   logic                       out_rend_ff, out_fend_ff;
   logic [gbd_pkg::PAIR_W:0]   block_sum;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         case (csr_index)
            gbd_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_data;
            gbd_pkg::CSR_IMAGE_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= gbd_pkg::WIDTH_RESET;
         height_ff <= gbd_pkg::HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // handshake
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign s1_free   = !s1_valid_ff || out_free;
   assign req_stall = !s1_free;
   assign accept    = req_valid && s1_free;

   gbd_addr_gen #(
      .MAX_WIDTH (MAX_WIDTH),
      .IDXW      (IDXW)
   ) u_addr_gen (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .pixel_value  (req_pixel_value),
      .frame_start  (req_frame_start),
      .image_width  (width_ff),
      .image_height (height_ff),
      .line_idx     (line_idx),
      .line_op      (line_op)
   );

   gbd_line_store #(
      .DEPTH (LINE_DEPTH),
      .IDXW  (IDXW)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (line_op.wr_en),
      .rd_en   (line_op.rd_en),
      .idx     (line_idx),
      .wr_data (line_op.pair),
      .rd_data (rd_data)
   );

   // read stage: wait for the stored partner pair
   assign s1_valid_in = s1_free ? line_op.rd_en : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (s1_free && line_op.rd_en) begin
         s1_pair_ff <= line_op.pair;
         s1_rend_ff <= line_op.row_end;
         s1_fend_ff <= line_op.frame_end;
      end
   end

   // output register
   assign block_sum    = {1'b0, rd_data} + {1'b0, s1_pair_ff};
   assign out_valid_in = out_free ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         out_pix_ff  <= block_sum[gbd_pkg::PAIR_W:2];
         out_rend_ff <= s1_rend_ff;
         out_fend_ff <= s1_fend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_scaled_pixel = out_pix_ff;
   assign rsp_row_end      = out_rend_ff;
   assign rsp_frame_end    = out_fend_ff;

   // a frame ends only on the last pixel of a row
   a_fend_rend : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_frame_end || rsp_row_end))
      else $error("frame_end without row_end");

   // one line store access per cycle
   a_one_access : assert property (@(posedge clock) disable iff (reset)
      !(line_op.rd_en && line_op.wr_en))
      else $error("line store read and write in one cycle");

   // a waiting read stage keeps its pair and the read data behind it
   a_s1_hold : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_pair_ff)
                                      && $stable(rd_data)))
      else $error("read stage lost its transaction under stall");

   // no line store read while the read stage cannot take it
   a_no_read_blocked : assert property (@(posedge clock) disable iff (reset)
      line_op.rd_en |-> s1_free)
      else $error("line store read issued into a blocked read stage");

endmodule

`default_nettype wire

>>> hw/rtl/gbd_line_store.sv
// ----------------------------------------------------------------------------
// gbd_line_store
// Pair sum line memory: one write or one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gbd_line_store #(
   parameter int DEPTH = gbd_pkg::MAX_WIDTH_DEFAULT / 2,
   parameter int IDXW  = $clog2(DEPTH)
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic                      rd_en,
   input  wire logic [IDXW-1:0]           idx,
   input  wire logic [gbd_pkg::PAIR_W-1:0] wr_data,
   output logic      [gbd_pkg::PAIR_W-1:0] rd_data
);

   logic [gbd_pkg::PAIR_W-1:0] mem [DEPTH];
   logic [gbd_pkg::PAIR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[idx] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/gbd_addr_gen.sv
// ----------------------------------------------------------------------------
// gbd_addr_gen
// Position counters, left pixel register and line store access decode.
// ----------------------------------------------------------------------------
`default_nettype none

module gbd_addr_gen #(
   parameter int MAX_WIDTH = gbd_pkg::MAX_WIDTH_DEFAULT,
   parameter int IDXW      = $clog2(MAX_WIDTH / 2)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       accept,
   input  wire logic [gbd_pkg::PIX_W-1:0]  pixel_value,
   input  wire logic                       frame_start,
   input  wire logic [gbd_pkg::CFG_W-1:0]  image_width,
   input  wire logic [gbd_pkg::CFG_W-1:0]  image_height,
   output logic      [IDXW-1:0]            line_idx,
   output gbd_pkg::line_op_type            line_op
);

   localparam int CW         = $clog2(MAX_WIDTH);
   localparam int WW         = (CW + 1 > gbd_pkg::CFG_W) ? CW + 1 : gbd_pkg::CFG_W;
   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int HW         = gbd_pkg::CFG_W;

   logic [CW-1:0]                col_ff, col_in, col;
   logic [gbd_pkg::ROW_W-1:0]    row_ff, row_in, row;
   logic [gbd_pkg::PIX_W-1:0]    left_ff, left_in;
   logic [WW-1:0]                iw_ext, w_eff, w_even, col_ext, half_w_m1, idx_ext;
   logic [HW-1:0]                h_eff, h_even, row_ext;
   logic [CW-2:0]                idx_full;
   logic                         active, rend;

   always_comb begin
      col = frame_start ? '0 : col_ff;
      row = frame_start ? '0 : row_ff;

      iw_ext = WW'(image_width);
      if (iw_ext < WW'(2)) begin
         w_eff = WW'(2);
      end else if (iw_ext > WW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = iw_ext;
      end
      if (image_height < HW'(2)) begin
         h_eff = HW'(2);
      end else if (image_height > HW'(gbd_pkg::HEIGHT_LIMIT)) begin
         h_eff = HW'(gbd_pkg::HEIGHT_LIMIT);
      end else begin
         h_eff = image_height;
      end

      w_even    = {w_eff[WW-1:1], 1'b0};
      h_even    = {h_eff[HW-1:1], 1'b0};
      col_ext   = WW'(col);
      row_ext   = HW'(row);
      idx_full  = col[CW-1:1];
      idx_ext   = WW'(idx_full);
      half_w_m1 = (w_eff >> 1) - WW'(1);

      active = col[0] && (col_ext < w_even) && (row_ext < h_even)
               && (idx_ext < WW'(LINE_DEPTH));
      rend   = (idx_ext == half_w_m1);

      line_idx          = idx_full[IDXW-1:0];
      line_op.pair      = {1'b0, left_ff} + {1'b0, pixel_value};
      line_op.wr_en     = accept && active && !row[0];
      line_op.rd_en     = accept && active && row[0];
      line_op.row_end   = rend;
      line_op.frame_end = rend && (row_ext == h_even - HW'(1));
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      left_in = left_ff;
      if (accept) begin
         if (!col[0]) begin
            left_in = pixel_value;
         end
         if (col_ext + WW'(1) >= w_eff) begin
            col_in = '0;
            row_in = (row_ext + HW'(1) >= h_eff) ? '0 : row + gbd_pkg::ROW_W'(1);
         end else begin
            col_in = col + CW'(1);
            row_in = row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         left_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         left_ff <= left_in;
      end
   end

endmodule

`default_nettype wire
